// ----- hw/rtl/mrht_pkg.sv -----
// Shared types and codes for the memory range hazard table.
package mrht_pkg;

   // Item action codes
   typedef enum logic [1:0] {
      ACT_CHECK = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_DRAIN = 2'd2
   } state_type;

   // One stored range, also used for the item being checked
   typedef struct packed {
      logic [63:0] buffer_id;
      logic [63:0] range_begin;
      logic [63:0] range_end;
      logic        range_kind;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);
   localparam int unsigned USED_W  = 9;

endpackage

// ----- hw/rtl/memory_range_hazard_table_top.sv -----
// Top level of the memory range hazard table: control, counters and entry RAM.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// request  | start && !busy       | req_action, req_buffer_id, req_range_begin,
//          |                      | req_range_end, req_range_kind
// response | rsp_strobe (1 cycle) | rsp_conflict, rsp_add_dropped, rsp_entries_used
//
// Add, clear and unused actions give their result strobe the cycle after accept,
// and busy stays low, so items may follow back to back.
// A check scans the entry RAM one entry a cycle through its single read port; the result
// strobes once the read data of the last held entry is compared, earlier on the first hit,
// and the cycle after accept when the table is empty or has overflowed.
// Synchronous reset empties the table and clears the overflow flag; RAM contents are
// not cleared, since only entries below the count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module memory_range_hazard_table_top #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_buffer_id,
   input  logic [63:0] req_range_begin,
   input  logic [63:0] req_range_end,
   input  logic        req_range_kind,
   output logic        rsp_strobe,
   output logic        rsp_conflict,
   output logic        rsp_add_dropped,
   output logic [8:0]  rsp_entries_used
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   // control state
   mrht_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                data_vld_ff, data_vld_in;
   logic                data_last_ff, data_last_in;

   // response registers
   logic rsp_strobe_ff, rsp_strobe_in;
   logic rsp_conflict_ff, rsp_conflict_in;
   logic rsp_dropped_ff, rsp_dropped_in;

   // item held for the scan
   mrht_pkg::entry_type item_ff, item_in;

   // RAM side
   mrht_pkg::entry_type req_entry;
   mrht_pkg::entry_type rd_entry;
   logic                wr_en;
   logic                rd_en;
   logic                hit;
   logic                accept;
   logic                full;
   logic                last_issue;
   logic [CNT_W+8:0]    used_wide;

   assign req_entry = '{buffer_id:   req_buffer_id,
                        range_begin: req_range_begin,
                        range_end:   req_range_end,
                        range_kind:  req_range_kind};

   assign busy       = (state_ff != mrht_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign full       = (count_ff == CNT_W'(TABLE_DEPTH));
   assign last_issue = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);

   mrht_ram #(
      .WIDTH (mrht_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_entry)
   );

   mrht_match u_match (
      .item   (item_ff),
      .stored (rd_entry),
      .hit    (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrht_pkg::ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         scan_idx_ff   <= '0;
         data_vld_ff   <= 1'b0;
         data_last_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         scan_idx_ff   <= scan_idx_in;
         data_vld_ff   <= data_vld_in;
         data_last_ff  <= data_last_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      rsp_conflict_ff <= rsp_conflict_in;
      rsp_dropped_ff  <= rsp_dropped_in;
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      scan_idx_in     = scan_idx_ff;
      data_vld_in     = 1'b0;
      data_last_in    = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_conflict_in = rsp_conflict_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      item_in         = item_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;

      unique case (state_ff)
         mrht_pkg::ST_IDLE: begin
            if (accept) begin
               item_in         = req_entry;
               rsp_conflict_in = 1'b0;
               rsp_dropped_in  = 1'b0;
               unique case (mrht_pkg::action_type'(req_action))
                  mrht_pkg::ACT_CHECK: begin
                     if (ovf_ff || (count_ff == '0)) begin
                        // answer at once: overflow is a conservative hit
                        rsp_conflict_in = ovf_ff;
                        rsp_strobe_in   = 1'b1;
                     end else begin
                        scan_idx_in = '0;
                        state_in    = mrht_pkg::ST_SCAN;
                     end
                  end
                  mrht_pkg::ACT_ADD: begin
                     if (full) begin
                        ovf_in         = 1'b1;
                        rsp_dropped_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  mrht_pkg::ACT_CLEAR: begin
                     count_in      = '0;
                     ovf_in        = 1'b0;
                     rsp_strobe_in = 1'b1;
                  end
                  mrht_pkg::ACT_NONE: begin
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         mrht_pkg::ST_SCAN, mrht_pkg::ST_DRAIN: begin
            if (state_ff == mrht_pkg::ST_SCAN) begin
               // issue one read per cycle until the last held entry
               rd_en        = 1'b1;
               data_vld_in  = 1'b1;
               data_last_in = last_issue;
               scan_idx_in  = scan_idx_ff + IDX_W'(1);
               if (last_issue) begin
                  state_in = mrht_pkg::ST_DRAIN;
               end
            end
            if (data_vld_ff && (hit || data_last_ff)) begin
               // first hit or last entry ends the scan; a read still in flight is dropped
               rsp_conflict_in = hit;
               rsp_strobe_in   = 1'b1;
               data_vld_in     = 1'b0;
               data_last_in    = 1'b0;
               rd_en           = 1'b0;
               state_in        = mrht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrht_pkg::ST_IDLE;
         end
      endcase
   end

   assign used_wide        = {9'd0, count_ff};
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_conflict     = rsp_conflict_ff;
   assign rsp_add_dropped  = rsp_dropped_ff;
   assign rsp_entries_used = used_wide[8:0];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_drop_sets_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_add_dropped) |-> ovf_ff)
      else $error("dropped add without overflow flag");

   a_fast_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action != mrht_pkg::ACT_CHECK)) |=> (rsp_strobe && !busy))
      else $error("non-check item missed its one-cycle result");

   a_data_in_scan: assert property (@(posedge clock) disable iff (reset)
      data_vld_ff |-> busy)
      else $error("read data pending outside a scan");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_conflict && rsp_add_dropped))
      else $error("conflict and dropped in one result");
`endif

endmodule

// ----- hw/rtl/mrht_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mrht_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mrht_match.sv -----
// Hazard compare of one stored range against the item under check.
module mrht_match (
   input  mrht_pkg::entry_type item,
   input  mrht_pkg::entry_type stored,
   output logic                hit
);

   logic same_buf;
   logic not_rr;
   logic overlap;

   assign same_buf = (stored.buffer_id == item.buffer_id);
   // read against read never conflicts
   assign not_rr   = item.range_kind | stored.range_kind;
   // end test is inclusive on the item side
   assign overlap  = (item.range_begin < stored.range_end) &&
                     (item.range_end >= stored.range_begin);
   assign hit      = same_buf && not_rr && overlap;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the memory range hazard table top level.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned DEPTH       = 256;
   // Longest legal quiet stretch is one full scan plus a long sender gap.
   localparam int unsigned STALL_LIMIT = 5000;

   // One request item as driven on the req_ ports.
   typedef struct {
      mrht_pkg::action_type act;
      mrht_pkg::entry_type  rng;
   } hazard_req_type;

   // One response item as seen on the rsp_ ports.
   typedef struct {
      logic       conflict;
      logic       add_dropped;
      logic [8:0] entries_used;
   } hazard_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = mrht_pkg::ACT_NONE;
   logic [63:0] req_buffer_id = '0;
   logic [63:0] req_range_begin = '0;
   logic [63:0] req_range_end = '0;
   logic        req_range_kind = 1'b0;
   logic        rsp_strobe;
   logic        rsp_conflict;
   logic        rsp_add_dropped;
   logic [8:0]  rsp_entries_used;

   // Stimulus waiting to be driven and responses still owed by the block.
   hazard_req_type pending_reqs[$];
   hazard_rsp_type expected_rsps[$];
   hazard_req_type cur_req;
   hazard_req_type next_req;
   hazard_rsp_type want_rsp;
   hazard_rsp_type got_rsp;

   // Shadow copy of the range table, updated at each accepted item.
   mrht_pkg::entry_type shadow_tbl[DEPTH];
   int unsigned         shadow_count = 0;
   logic                shadow_overflow = 1'b0;

   int unsigned sender_idle_pct = 14;
   int unsigned live_items_queued = 0;
   int unsigned stall_cycles = 0;
   int unsigned err_count = 0;
   int unsigned n_checks = 0;
   int unsigned n_adds = 0;
   int unsigned n_clears = 0;
   int unsigned n_conflicts = 0;
   int unsigned n_dropped = 0;
   int unsigned peak_used = 0;

   memory_range_hazard_table_top #(
      .TABLE_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_buffer_id(req_buffer_id),
      .req_range_begin(req_range_begin),
      .req_range_end(req_range_end),
      .req_range_kind(req_range_kind),
      .rsp_strobe(rsp_strobe),
      .rsp_conflict(rsp_conflict),
      .rsp_add_dropped(rsp_add_dropped),
      .rsp_entries_used(rsp_entries_used)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction: apply one accepted item to the shadow table.
   // A check hits when an entry has the same buffer, is not read vs read, and
   // begin < entry_end && end >= entry_begin (end test inclusive). An overflowed
   // table flags every check. Clear also drops the overflow flag.
   // ---------------------------------------------------------------------------
   task automatic predict_hazard(input hazard_req_type r, output hazard_rsp_type o);
      int unsigned i;
      o.conflict = 1'b0;
      o.add_dropped = 1'b0;
      case (r.act)
         mrht_pkg::ACT_CHECK: begin
            if (shadow_overflow) begin
               o.conflict = 1'b1;
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  if (shadow_tbl[i].buffer_id == r.rng.buffer_id &&
                      (r.rng.range_kind || shadow_tbl[i].range_kind) &&
                      r.rng.range_begin < shadow_tbl[i].range_end &&
                      r.rng.range_end >= shadow_tbl[i].range_begin)
                     o.conflict = 1'b1;
               end
            end
         end
         mrht_pkg::ACT_ADD: begin
            if (shadow_count < DEPTH) begin
               shadow_tbl[shadow_count] = r.rng;
               shadow_count++;
            end else begin
               // full table: item is dropped and the flag sticks until a clear
               shadow_overflow = 1'b1;
               o.add_dropped = 1'b1;
            end
         end
         mrht_pkg::ACT_CLEAR: begin
            shadow_count = 0;
            shadow_overflow = 1'b0;
         end
         default: begin
            // unused action code leaves the table alone
         end
      endcase
      o.entries_used = shadow_count[8:0];
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_req(input mrht_pkg::action_type act, input logic [63:0] id,
                           input logic [63:0] lo, input logic [63:0] hi,
                           input logic kind);
      hazard_req_type r;
      r.act = act;
      r.rng.buffer_id = id;
      r.rng.range_begin = lo;
      r.rng.range_end = hi;
      r.rng.range_kind = kind;
      pending_reqs = {pending_reqs, r};
      if (act != mrht_pkg::ACT_NONE)
         live_items_queued++;
   endtask

   // Begin address: mostly inside a small window so ranges collide.
   function automatic logic [63:0] pick_begin(input logic [63:0] base);
      if ($urandom_range(0, 99) < 85)
         return base + 64'($urandom_range(0, 63));
      return rand64();
   endfunction

   // End address: short ranges, empty ones, inverted ones and wild ones.
   function automatic logic [63:0] pick_end(input logic [63:0] lo);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)
         return lo + 64'($urandom_range(1, 16));
      if (sel < 75)
         return lo;
      if (sel < 88)
         return lo - 64'($urandom_range(1, 16));
      return rand64();
   endfunction

   // Directed opener: boundary tests of the overlap rule, read/read pass,
   // extremes of every field, unused action and clear.
   task automatic queue_directed();
      logic [63:0] ones;
      logic [63:0] alt;
      ones = '1;
      alt = {16{4'hA}};
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h0, ones, 1'b1);          // empty table
      push_req(mrht_pkg::ACT_NONE, ones, ones, ones, 1'b1);             // unused code
      push_req(mrht_pkg::ACT_ADD, 64'h0, 64'h100, 64'h200, 1'b1);       // write [100,200)
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h1ff, 64'h210, 1'b0);     // plain overlap
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h200, 64'h300, 1'b1);     // begin at entry end
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h80, 64'h100, 1'b0);      // end at entry begin
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h80, 64'hff, 1'b1);       // just below
      push_req(mrht_pkg::ACT_CHECK, 64'h1, 64'h100, 64'h200, 1'b1);     // other buffer
      push_req(mrht_pkg::ACT_ADD, ones, ones - 64'd16, ones, 1'b0);     // read at the top
      push_req(mrht_pkg::ACT_CHECK, ones, ones - 64'd8, ones, 1'b0);    // read vs read
      push_req(mrht_pkg::ACT_CHECK, ones, ones - 64'd8, ones, 1'b1);    // write vs read
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h1f0, 64'h150, 1'b0);     // inverted range
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h300, 64'h50, 1'b1);      // inverted, no hit
      push_req(mrht_pkg::ACT_ADD, alt, 64'h0, ones, 1'b1);              // whole space
      push_req(mrht_pkg::ACT_CHECK, alt, ones, ones, 1'b0);             // begin == entry end
      push_req(mrht_pkg::ACT_CHECK, alt, 64'h0, 64'h0, 1'b0);           // zero-length at 0
      push_req(mrht_pkg::ACT_CHECK, ~alt, 64'h40, 64'h80, 1'b1);        // complement buffer
      push_req(mrht_pkg::ACT_NONE, 64'h0, 64'h0, 64'h0, 1'b0);          // unused, table held
      push_req(mrht_pkg::ACT_CLEAR, ~alt, ones, 64'h0, 1'b1);
      push_req(mrht_pkg::ACT_CHECK, 64'h0, 64'h100, 64'h200, 1'b1);     // after clear
      push_req(mrht_pkg::ACT_ADD, ~alt, ~alt, alt, 1'b0);
      push_req(mrht_pkg::ACT_CHECK, ~alt, alt, ~alt, 1'b1);
   endtask

   // One burst of related items: shared buffer ids and address window.
   task automatic queue_episode(input int unsigned len);
      logic [63:0] ids[3];
      logic [63:0] base;
      logic [63:0] lo;
      int unsigned k;
      int unsigned sel;
      ids[0] = rand64();
      ids[1] = $urandom_range(0, 1) ? '1 : '0;
      ids[2] = 64'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: base = '0;
         1: base = 64'hFFFF_FFFF_FFFF_FFC0;
         default: base = rand64();
      endcase
      if ($urandom_range(0, 1))
         push_req(mrht_pkg::ACT_CLEAR, rand64(), rand64(), rand64(), 1'($urandom));
      for (k = 0; k < len; k++) begin
         sel = $urandom_range(0, 99);
         lo = pick_begin(base);
         if (sel < 45)
            push_req(mrht_pkg::ACT_CHECK, ids[$urandom_range(0, 2)], lo, pick_end(lo),
                     1'($urandom));
         else if (sel < 88)
            push_req(mrht_pkg::ACT_ADD, ids[$urandom_range(0, 2)], lo, pick_end(lo),
                     1'($urandom));
         else if (sel < 95)
            push_req(mrht_pkg::ACT_NONE, rand64(), lo, pick_end(lo), 1'($urandom));
         else if (sel < 97)
            push_req(mrht_pkg::ACT_CHECK, rand64(), rand64(), rand64(), 1'($urandom));
         else
            push_req(mrht_pkg::ACT_CLEAR, rand64(), lo, pick_end(lo), 1'($urandom));
      end
   endtask

   // Fill the table past capacity: checks on a filling table, drops, checks
   // with the sticky flag up, then a clear to recover.
   task automatic queue_overflow_run();
      logic [63:0] id;
      logic [63:0] base;
      logic [63:0] lo;
      int unsigned k;
      id = rand64();
      base = rand64();
      push_req(mrht_pkg::ACT_CLEAR, id, base, base, 1'b0);
      for (k = 0; k < DEPTH + 4; k++) begin
         lo = base + 64'(k * 32);
         push_req(mrht_pkg::ACT_ADD, id, lo, lo + 64'($urandom_range(1, 32)),
                  1'($urandom));
         if (k % 48 == 47) begin
            lo = pick_begin(base);
            push_req(mrht_pkg::ACT_CHECK, id, lo, pick_end(lo), 1'($urandom));
         end
      end
      for (k = 0; k < 8; k++)
         push_req(mrht_pkg::ACT_CHECK, rand64(), rand64(), rand64(), 1'($urandom));
      push_req(mrht_pkg::ACT_ADD, id, base, base + 64'd4, 1'b1);
      push_req(mrht_pkg::ACT_CLEAR, id, base, base, 1'b1);
      push_req(mrht_pkg::ACT_CHECK, id, base, base + 64'd4, 1'b1);
   endtask

   task automatic queue_random(input int unsigned budget);
      int unsigned target;
      target = live_items_queued + budget;
      while (live_items_queued < target)
         queue_episode($urandom_range(8, 60));
   endtask

   // Wait until every queued item is accepted and every response is back.
   // Sampled on the falling edge, clear of the driver and monitor updates.
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: start/busy handshake. An item is taken at a rising edge with
   // start high and busy low; the prediction is made right there, so the
   // expected queue stays in acceptance order. start is held high while busy
   // and may drop for random gaps, so gaps land both on idle and scan cycles.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_hazard(cur_req, want_rsp);
            expected_rsps = {expected_rsps, want_rsp};
            case (cur_req.act)
               mrht_pkg::ACT_CHECK: n_checks++;
               mrht_pkg::ACT_ADD:   n_adds++;
               mrht_pkg::ACT_CLEAR: n_clears++;
               default: ;
            endcase
         end
         if (!start || !busy) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_req = pending_reqs.pop_front();
               cur_req = next_req;
               req_action <= next_req.act;
               req_buffer_id <= next_req.rng.buffer_id;
               req_range_begin <= next_req.rng.range_begin;
               req_range_end <= next_req.rng.range_end;
               req_range_kind <= next_req.rng.range_kind;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: each strobe carries one response; compare against the oldest
   // outstanding prediction, field by field.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_rsp.conflict = rsp_conflict;
         got_rsp.add_dropped = rsp_add_dropped;
         got_rsp.entries_used = rsp_entries_used;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, conflict %0b dropped %0b used %0d",
                     $time, got_rsp.conflict, got_rsp.add_dropped, got_rsp.entries_used);
            err_count++;
         end else begin
            want_rsp = expected_rsps.pop_front();
            if (got_rsp.conflict !== want_rsp.conflict) begin
               $display("%0t: conflict expected %0b, got %0b",
                        $time, want_rsp.conflict, got_rsp.conflict);
               err_count++;
            end
            if (got_rsp.add_dropped !== want_rsp.add_dropped) begin
               $display("%0t: add_dropped expected %0b, got %0b",
                        $time, want_rsp.add_dropped, got_rsp.add_dropped);
               err_count++;
            end
            if (got_rsp.entries_used !== want_rsp.entries_used) begin
               $display("%0t: entries_used expected %0d, got %0d",
                        $time, want_rsp.entries_used, got_rsp.entries_used);
               err_count++;
            end
            if (want_rsp.conflict)
               n_conflicts++;
            if (want_rsp.add_dropped)
               n_dropped++;
            if (want_rsp.entries_used > peak_used)
               peak_used = want_rsp.entries_used;
         end
      end
   end

   // Watchdog: too long with neither an accepted item nor a response.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed items, then three random phases with the
   // sender idling 14%, 88% and never. The last phase also runs the table
   // into overflow and back out.
   // ---------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 14;
      queue_directed();
      queue_random(200);
      wait_drained();

      sender_idle_pct = 88;
      queue_random(100);
      wait_drained();

      sender_idle_pct = 0;
      queue_random(120);
      queue_overflow_run();
      queue_random(80);
      wait_drained();

      // allow for a stray late response: one full scan and a margin
      repeat (DEPTH + 8) @(negedge clock);

      $display("Covered %0d checks (%0d flagged), %0d adds (%0d dropped), %0d clears;",
               n_checks, n_conflicts, n_adds, n_dropped, n_clears);
      $display("table peaked at %0d entries, sender idle at 14%%, 88%% and 0%%.",
               peak_used);
      if (err_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
